FILE: design/sact_pkg.sv
// sact_pkg: shared types and constants of the set-associative cache tag controller
// no dependencies; imported by the front, back and top modules

package sact_pkg;

    // request opcodes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_INVAL = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_BLOCK_OFFSET = 3'd0,
        REG_USE_RANDOM   = 3'd1,
        REG_WRITE_THRU   = 3'd2,
        REG_CACHE_CYC    = 3'd3,
        REG_MEM_CYC      = 3'd4,
        REG_SEED         = 3'd5
    } t_reg_idx;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_OFFSET  = 12;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // result packing
    localparam int ACC_W   = 18;
    localparam int CNT_W   = 32;
    localparam int TOTAL_W = 48;
    localparam int RES_W   = 3 + ACC_W + 3 * CNT_W + TOTAL_W;
    localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

    // configuration seen by the datapath
    typedef struct packed {
        logic [3:0]  block_offset_bits;
        logic        use_random;
        logic        write_through;
        logic [9:0]  cache_cycles;
        logic [15:0] memory_cycles;
    } t_cfg;

    // seed load request to the back end
    typedef struct packed {
        logic        load;
        logic [15:0] seed;
    } t_seed;

endpackage

FILE: design/sact_front.sv
// sact_front: accepts requests, splits the address into set and tag, queues them
// depends on sact_pkg

module sact_front #(
    parameter int NUM_SETS  = 64,
    parameter int ADDR_BITS = 48,
    parameter int SET_W     = 6,
    parameter int TAG_W     = 42
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sact_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output logic [1:0]           o_q_op,
    output logic [SET_W-1:0]     o_q_set,
    output logic [TAG_W-1:0]     o_q_tag
);
    import sact_pkg::*;

    localparam int DEPTH = 2;

    logic [3:0]           w_off;
    logic [ADDR_BITS-1:0] w_blk;
    logic [SET_W-1:0]     w_set;
    logic [TAG_W-1:0]     w_tag;
    logic                 w_push;

    logic [1:0]       r_op  [DEPTH];
    logic [SET_W-1:0] r_set [DEPTH];
    logic [TAG_W-1:0] r_tag [DEPTH];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;

    // address split
    always_comb begin
        w_off = (i_cfg.block_offset_bits > 4'(MAX_OFFSET)) ? 4'(MAX_OFFSET)
                                                           : i_cfg.block_offset_bits;
        w_blk = i_addr >> w_off;
        w_set = SET_W'(w_blk % NUM_SETS);
        w_tag = TAG_W'(w_blk / NUM_SETS);
    end

    // queue control
    assign o_ready   = (r_count != 2'(DEPTH));
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_op    = r_op[r_rd_ptr];
    assign o_q_set   = r_set[r_rd_ptr];
    assign o_q_tag   = r_tag[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_op[r_wr_ptr]  <= i_op;
            r_set[r_wr_ptr] <= w_set;
            r_tag[r_wr_ptr] <= w_tag;
        end
    end

endmodule

FILE: design/sact_back.sv
// sact_back: reads one set, resolves hit or replacement, updates state and totals
// depends on sact_pkg

module sact_back #(
    parameter int NUM_SETS = 64,
    parameter int NUM_WAYS = 4,
    parameter int SET_W    = 6,
    parameter int TAG_W    = 42,
    parameter int WAY_W    = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sact_pkg::t_cfg             i_cfg,
    input  sact_pkg::t_seed            i_seed,
    input  logic                       i_q_valid,
    output logic                       o_q_pop,
    input  logic [1:0]                 i_q_op,
    input  logic [SET_W-1:0]           i_q_set,
    input  logic [TAG_W-1:0]           i_q_tag,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sact_pkg::OUT_W-1:0] o_data
);
    import sact_pkg::*;

    typedef enum logic [1:0] {
        S_READ = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // set memories and per-line flags
    logic [NUM_WAYS-1:0][TAG_W-1:0] r_tag_mem   [NUM_SETS];
    logic [NUM_WAYS-1:0]            r_dirty_mem [NUM_SETS];
    logic [NUM_WAYS-1:0][WAY_W-1:0] r_rank_mem  [NUM_SETS];
    logic [NUM_WAYS-1:0]            r_valid     [NUM_SETS];
    logic [NUM_SETS-1:0]            r_rank_init;

    logic [NUM_WAYS-1:0][TAG_W-1:0] r_rd_tag;
    logic [NUM_WAYS-1:0]            r_rd_dirty;
    logic [NUM_WAYS-1:0][WAY_W-1:0] r_rd_rank;

    logic [1:0]       r_op;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;

    logic [15:0]        r_lfsr, n_lfsr;
    logic [CNT_W-1:0]   r_hits, r_misses, r_evicts;
    logic [TOTAL_W-1:0] r_total;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic                           w_commit;
    logic [NUM_WAYS-1:0]            w_vld, n_vld;
    logic [NUM_WAYS-1:0]            w_dirty, n_dirty;
    logic [NUM_WAYS-1:0][WAY_W-1:0] w_rank, n_rank;
    logic [NUM_WAYS-1:0][TAG_W-1:0] n_tag;
    logic                           w_rw, w_wr;
    logic                           w_hit, w_empty, w_evict, w_dirty_ev, w_promote;
    logic [WAY_W-1:0]               w_fidx, w_eidx, w_vidx, w_target, w_want;
    logic [WAY_W:0]                 w_best;
    logic [15:0]                    w_lfsr_adv;
    logic [ACC_W-1:0]               w_cyc;
    logic [CNT_W-1:0]               n_hits, n_misses, n_evicts;
    logic [TOTAL_W-1:0]             n_total;

    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || i_ready);
    assign o_q_pop  = (r_state == S_READ) && i_q_valid;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_READ:  if (i_q_valid) n_state = S_EXEC;
            S_EXEC:  if (w_commit) n_state = S_READ;
            default: n_state = S_READ;
        endcase
    end

    // registered set read at dequeue
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op       <= i_q_op;
            r_set      <= i_q_set;
            r_tag      <= i_q_tag;
            r_rd_tag   <= r_tag_mem[i_q_set];
            r_rd_dirty <= r_dirty_mem[i_q_set];
            r_rd_rank  <= r_rank_mem[i_q_set];
        end
    end

    // lookup and replacement choice
    always_comb begin
        w_vld   = r_valid[r_set];
        w_dirty = r_rd_dirty & w_vld;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_rank[w] = r_rank_init[r_set] ? r_rd_rank[w] : WAY_W'(w);
        end
        w_rw = (r_op == OP_READ) || (r_op == OP_WRITE);
        w_wr = (r_op == OP_WRITE);

        // an unused op never reports a match
        w_hit  = 1'b0;
        w_fidx = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if ((r_op != OP_NONE) && w_vld[w] && (r_rd_tag[w] == r_tag) && !w_hit) begin
                w_hit  = 1'b1;
                w_fidx = WAY_W'(w);
            end
        end

        w_empty = 1'b0;
        w_eidx  = '0;
        w_best  = '1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!w_vld[w] && ({1'b0, w_rank[w]} < w_best)) begin
                w_best  = {1'b0, w_rank[w]};
                w_eidx  = WAY_W'(w);
                w_empty = 1'b1;
            end
        end

        w_lfsr_adv = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 16'h0000);
        w_want     = i_cfg.use_random ? WAY_W'(w_lfsr_adv % 16'(NUM_WAYS))
                                      : WAY_W'(NUM_WAYS - 1);
        w_vidx = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w_rank[w] == w_want) w_vidx = WAY_W'(w);
        end

        w_target   = w_hit ? w_fidx : (w_empty ? w_eidx : w_vidx);
        w_evict    = w_rw && !w_hit && !w_empty;
        w_dirty_ev = w_evict && w_dirty[w_vidx];
        w_promote  = w_hit || w_empty || !i_cfg.use_random;
    end

    // next line state
    always_comb begin
        n_vld   = w_vld;
        n_dirty = w_dirty;
        n_tag   = r_rd_tag;
        n_rank  = w_rank;
        if (r_op == OP_INVAL) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (w_vld[w] && (r_rd_tag[w] == r_tag)) begin
                    n_vld[w]   = 1'b0;
                    n_dirty[w] = 1'b0;
                end
            end
        end else if (w_rw) begin
            if (w_hit) begin
                n_dirty[w_target] = w_dirty[w_target] | w_wr;
            end else begin
                n_tag[w_target]   = r_tag;
                n_vld[w_target]   = 1'b1;
                n_dirty[w_target] = w_wr;
            end
            if (w_promote) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (WAY_W'(w) == w_target) begin
                        n_rank[w] = '0;
                    end else if (w_rank[w] < w_rank[w_target]) begin
                        n_rank[w] = w_rank[w] + 1'b1;
                    end
                end
            end
        end
    end

    // cycle cost and totals
    always_comb begin
        w_cyc = '0;
        if (r_op == OP_READ) begin
            if (w_dirty_ev) begin
                w_cyc = ACC_W'(i_cfg.cache_cycles) + ACC_W'({i_cfg.memory_cycles, 1'b0});
            end else if (w_hit) begin
                w_cyc = ACC_W'(i_cfg.cache_cycles);
            end else begin
                w_cyc = ACC_W'(i_cfg.cache_cycles) + ACC_W'(i_cfg.memory_cycles);
            end
        end else if (r_op == OP_WRITE) begin
            if (i_cfg.write_through || w_dirty_ev) begin
                w_cyc = ACC_W'(i_cfg.cache_cycles) + ACC_W'(i_cfg.memory_cycles);
            end else begin
                w_cyc = ACC_W'(i_cfg.cache_cycles);
            end
        end
        n_hits   = r_hits + CNT_W'(w_rw && w_hit);
        n_misses = r_misses + CNT_W'(w_rw && !w_hit);
        n_evicts = r_evicts + CNT_W'(w_evict);
        n_total  = r_total + TOTAL_W'(w_cyc);
    end

    // lfsr next value
    always_comb begin
        n_lfsr = r_lfsr;
        if (i_seed.load) begin
            n_lfsr = (i_seed.seed != 16'h0000) ? i_seed.seed : 16'h0001;
        end else if (w_commit && w_evict && i_cfg.use_random) begin
            n_lfsr = w_lfsr_adv;
        end
    end

    // control and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READ;
            r_lfsr      <= 16'h0001;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_rank_init <= '0;
            for (int s = 0; s < NUM_SETS; s++) r_valid[s] <= '0;
        end else begin
            r_state <= n_state;
            r_lfsr  <= n_lfsr;
            if (w_commit) begin
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_evicts    <= n_evicts;
                r_total     <= n_total;
                r_out_valid <= 1'b1;
                if (r_op != OP_NONE) begin
                    r_valid[r_set]     <= n_vld;
                    r_rank_init[r_set] <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // set memory write and result register
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            if (r_op != OP_NONE) begin
                r_tag_mem[r_set]   <= n_tag;
                r_dirty_mem[r_set] <= n_dirty;
                r_rank_mem[r_set]  <= n_rank;
            end
            r_out_data <= OUT_W'({n_total, n_evicts, n_misses, n_hits, w_cyc,
                                  w_dirty_ev, w_evict, w_hit});
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef SYNTH
    // a result never reports both a hit and an eviction
    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[1]))
        else $error("hit and eviction in one result");

    // a dirty eviction is always an eviction
    a_dirty_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[2] |-> r_out_data[1])
        else $error("dirty eviction without eviction");

    // the victim lfsr never locks up at zero
    a_lfsr_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 16'h0000)
        else $error("lfsr reached zero");

    // an update with a free output slot completes by the next cycle
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && !r_out_valid |=> (r_state == S_READ) && r_out_valid)
        else $error("update did not complete");
`endif

endmodule

FILE: design/set_assoc_cache_tag_controller.sv
// set_assoc_cache_tag_controller: top level with configuration registers
// depends on sact_pkg, sact_front, sact_back

// Set-associative tag controller for read, write and invalidate requests. Each
// request on the slave stream gives exactly one result on the master stream with
// hit, eviction, dirty eviction, cycle cost and running totals. A front stage
// splits the address and holds up to two requests; the back end handles one
// request at a time (a registered read of the set row, then the update of
// tags, flags and LRU ranks) and takes the next request only after that update,
// which waits while the result register still holds an untaken result.
// The result register lets the next request proceed while a result waits. The user must
// write configuration through the plain write port only while no request is in flight;
// the block itself does not enforce this. No clearing pass is needed after reset.

module set_assoc_cache_tag_controller #(
    parameter int NUM_SETS  = 64,
    parameter int NUM_WAYS  = 4,
    parameter int ADDR_BITS = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sact_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sact_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // op[1:0], address[ADDR_BITS+1:2], zero fill
    input  logic [((ADDR_BITS+2+7)/8)*8-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hit, eviction, dirty_eviction, access_cycles[17:0], hit_count[31:0],
    // miss_count[31:0], eviction_count[31:0], total_cycles[47:0], zero fill
    output logic [sact_pkg::OUT_W-1:0]        m_axis_tdata
);
    import sact_pkg::*;

    localparam int SET_LOG = $clog2(NUM_SETS);
    localparam int SET_W   = (SET_LOG > 0) ? SET_LOG : 1;
    localparam int TAG_W   = ADDR_BITS - SET_LOG + (((1 << SET_LOG) == NUM_SETS) ? 0 : 1);
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    t_cfg  r_cfg;
    t_seed w_seed;

    logic             w_q_valid, w_q_pop;
    logic [1:0]       w_q_op;
    logic [SET_W-1:0] w_q_set;
    logic [TAG_W-1:0] w_q_tag;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_offset_bits <= 4'd6;
            r_cfg.use_random        <= 1'b0;
            r_cfg.write_through     <= 1'b0;
            r_cfg.cache_cycles      <= 10'd1;
            r_cfg.memory_cycles     <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_OFFSET: r_cfg.block_offset_bits <= i_cfg_data[3:0];
                REG_USE_RANDOM:   r_cfg.use_random        <= i_cfg_data[0];
                REG_WRITE_THRU:   r_cfg.write_through     <= i_cfg_data[0];
                REG_CACHE_CYC:    r_cfg.cache_cycles      <= i_cfg_data[9:0];
                REG_MEM_CYC:      r_cfg.memory_cycles     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // seed write reloads the victim lfsr
    assign w_seed.load = i_cfg_we && (i_cfg_idx == REG_SEED);
    assign w_seed.seed = i_cfg_data;

    sact_front #(
        .NUM_SETS  (NUM_SETS),
        .ADDR_BITS (ADDR_BITS),
        .SET_W     (SET_W),
        .TAG_W     (TAG_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_op      (s_axis_tdata[1:0]),
        .i_addr    (s_axis_tdata[ADDR_BITS+1:2]),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_op    (w_q_op),
        .o_q_set   (w_q_set),
        .o_q_tag   (w_q_tag)
    );

    sact_back #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W),
        .WAY_W    (WAY_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_seed    (w_seed),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_op    (w_q_op),
        .i_q_set   (w_q_set),
        .i_q_tag   (w_q_tag),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule
